// ===== rtl/core/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// shared types and constants of the variable partition allocator
// ----------------------------------------------------------------------------
package vpa_pkg;

   localparam int SEGMENTS  = 16;
   localparam int ADDR_BITS = 16;
   localparam int SIZE_BITS = 17;
   localparam int CNT_BITS  = $clog2(SEGMENTS + 1);
   localparam int IDX_BITS  = $clog2(SEGMENTS);

   localparam logic [SIZE_BITS-1:0] SIZE_MAX   = '1;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(65536);

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_TOTAL  = 1'b1;

   // segment entry travelling along the chain
   typedef struct packed {
      logic                 vld;
      logic [ADDR_BITS-1:0] start;
      logic [SIZE_BITS-1:0] size;
   } seg_type;

   // command from the sequencer to every cell
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INIT,
      CMD_ROTATE,
      CMD_WRITE,
      CMD_REMOVE,
      CMD_INSERT
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [IDX_BITS-1:0]  idx;
      seg_type              seg;
   } ctl_type;

endpackage

// ===== rtl/core/variable_partition_allocator_core.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator_core
// first, best or worst fit segment allocator with coalescing release
// ----------------------------------------------------------------------------
// req_ carries one operation word: kind in tuser, addr and size in tdata.
// rsp_ returns one result word per request. csr_ writes the fit policy
// (index 0) or the managed size (index 1, rebuilds the table, clears counters).
// The free table is a ring of SEGMENTS cells. A request rotates the ring once
// past the head cell, one cell per cycle, to scan sizes and find the insert
// point, then an update step (write, remove shift or insert shift), plus a
// predecessor write when a release merges on both sides, then one more full
// rotation to sum the free total and largest segment.
// One request is in flight at a time.
// Reset leaves one free segment covering the whole 65536 units, first fit.
// A finished result is held in the output register while rsp_tready is low;
// req_tready stays low until it has been taken.
// ----------------------------------------------------------------------------
module variable_partition_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // addr[15:0], size[32:16], zero fill
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [127:0] rsp_tdata,  // status, alloc_addr, free_total,
                                    // fragmentation, segment_count,
                                    // allocations_done, releases_done
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import vpa_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPDATE, S_FIX, S_SUM, S_OUT} state_type;

   state_type              state_ff;
   logic [1:0]             policy_ff;
   logic [CNT_BITS-1:0]    used_ff;
   logic [31:0]            acnt_ff, rcnt_ff;
   logic                   kind_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [SIZE_BITS-1:0]   len_ff;
   logic [CNT_BITS-1:0]    step_ff;
   logic                   found_ff;
   logic [IDX_BITS-1:0]    pick_ff;
   seg_type                pseg_ff;
   logic [CNT_BITS-1:0]    pos_ff;     // first index with start >= addr
   logic                   pfound_ff;
   seg_type                before_ff;  // entry at pos-1
   seg_type                after_ff;   // entry at pos
   logic [SIZE_BITS+3:0]   sum_ff;
   logic [SIZE_BITS-1:0]   big_ff;
   logic [1:0]             status_ff;
   logic [ADDR_BITS-1:0]   got_ff;
   logic                   rvalid_ff;
   logic [127:0]           rdata_ff;
   logic [IDX_BITS-1:0]    fix_idx_ff;
   seg_type                fix_seg_ff;
   ctl_type                ctl;
   seg_type                head, init_seg;

   vpa_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .first_init (init_seg),
      .head       (head)
   );

   logic                 csr_total;
   logic [IDX_BITS-1:0]  step_idx;
   logic                 in_range, fits, better;
   logic                 wprev, wnext;
   logic [SIZE_BITS:0]   pend;
   logic [ADDR_BITS-1:0] ns;
   logic [SIZE_BITS:0]   nz;
   logic [SIZE_BITS+1:0] nz2;
   logic [SIZE_BITS+1:0] nend;

   assign csr_total = csr_we && csr_index == CSR_TOTAL;
   assign init_seg  = csr_total ? seg_type'{csr_wdata != '0, '0, csr_wdata}
                                : seg_type'{1'b1, '0, SIZE_RESET};
   assign step_idx  = step_ff[IDX_BITS-1:0];
   assign in_range  = step_ff < used_ff;
   assign fits      = head.size >= len_ff;
   assign better    = (policy_ff == POL_BEST)  ? head.size < pseg_ff.size :
                      (policy_ff == POL_WORST) ? head.size > pseg_ff.size : 1'b0;

   assign pend  = {2'b0, before_ff.start} + {1'b0, before_ff.size};
   assign wprev = pos_ff != '0 && pend == (SIZE_BITS+1)'(addr_ff);
   assign ns    = wprev ? before_ff.start : addr_ff;
   assign nz    = wprev ? {1'b0, before_ff.size} + {1'b0, len_ff} : {1'b0, len_ff};
   assign nend  = (SIZE_BITS+2)'(ns) + (SIZE_BITS+2)'(nz);
   assign wnext = pos_ff < used_ff && nend == (SIZE_BITS+2)'(after_ff.start);
   assign nz2   = {1'b0, nz} + {2'b0, after_ff.size};

   function automatic logic [SIZE_BITS-1:0] sat(input logic [SIZE_BITS+3:0] v);
      return (|v[SIZE_BITS+3:SIZE_BITS]) ? SIZE_MAX : v[SIZE_BITS-1:0];
   endfunction

   always_comb begin
      ctl = '{CMD_HOLD, '0, '0};
      if (csr_total) begin
         ctl.cmd = CMD_INIT;
      end else begin
         unique case (state_ff)
            S_SCAN, S_SUM: ctl.cmd = CMD_ROTATE;
            S_FIX: begin
               ctl.cmd = CMD_WRITE;
               ctl.idx = fix_idx_ff;
               ctl.seg = fix_seg_ff;
            end
            S_UPDATE: begin
               if (kind_ff == 1'b0) begin
                  if (found_ff) begin
                     if (pseg_ff.size == len_ff) begin
                        ctl.cmd = CMD_REMOVE;
                        ctl.idx = pick_ff;
                     end else begin
                        ctl.cmd = CMD_WRITE;
                        ctl.idx = pick_ff;
                        ctl.seg = '{1'b1, pseg_ff.start + ADDR_BITS'(len_ff),
                                    pseg_ff.size - len_ff};
                     end
                  end
               end else if (len_ff != '0) begin
                  if (wprev && wnext) begin
                     ctl.cmd = CMD_REMOVE;  // drop pos, then write pos-1 below
                     ctl.idx = pos_ff[IDX_BITS-1:0];
                  end else if (wprev) begin
                     ctl.cmd = CMD_WRITE;
                     ctl.idx = IDX_BITS'(pos_ff - 1'b1);
                     ctl.seg = '{1'b1, before_ff.start, sat({3'b0, nz})};
                  end else if (wnext) begin
                     ctl.cmd = CMD_WRITE;
                     ctl.idx = pos_ff[IDX_BITS-1:0];
                     ctl.seg = '{1'b1, ns, sat({2'b0, nz2})};
                  end else if (used_ff < CNT_BITS'(SEGMENTS)) begin
                     ctl.cmd = CMD_INSERT;
                     ctl.idx = pos_ff[IDX_BITS-1:0];
                     ctl.seg = '{1'b1, ns, nz[SIZE_BITS-1:0]};
                  end
               end
            end
            default: ctl.cmd = CMD_HOLD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         policy_ff <= POL_FIRST;
         used_ff   <= CNT_BITS'(1);
         acnt_ff   <= '0;
         rcnt_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_POLICY) policy_ff <= csr_wdata[1:0];
         if (csr_total) begin
            used_ff  <= (csr_wdata != '0) ? CNT_BITS'(1) : '0;
            acnt_ff  <= '0;
            rcnt_ff  <= '0;
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid && !rvalid_ff) begin
               kind_ff   <= req_tuser;
               addr_ff   <= req_tdata[ADDR_BITS-1:0];
               len_ff    <= req_tdata[32:16];
               step_ff   <= '0;
               found_ff  <= 1'b0;
               pfound_ff <= 1'b0;
               pos_ff    <= used_ff;
               before_ff <= '0;
               after_ff  <= '0;
               state_ff  <= S_SCAN;
            end
            S_SCAN: begin
               if (in_range) begin
                  if (fits && (!found_ff || better)) begin
                     found_ff <= 1'b1;
                     pick_ff  <= step_idx;
                     pseg_ff  <= head;
                  end
                  if (!pfound_ff) begin
                     if (head.start >= addr_ff) begin
                        pfound_ff <= 1'b1;
                        pos_ff    <= step_ff;
                        after_ff  <= head;
                     end else begin
                        before_ff <= head;
                     end
                  end
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == CNT_BITS'(SEGMENTS-1)) state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               status_ff <= ST_DONE;
               got_ff    <= '0;
               if (kind_ff == 1'b0) begin
                  if (found_ff) begin
                     got_ff  <= pseg_ff.start;
                     acnt_ff <= acnt_ff + 1'b1;
                     if (pseg_ff.size == len_ff) used_ff <= used_ff - 1'b1;
                  end else begin
                     status_ff <= ST_NOFIT;
                  end
               end else if (len_ff == '0) begin
                  rcnt_ff <= rcnt_ff + 1'b1;
               end else if (wprev && wnext) begin
                  used_ff    <= used_ff - 1'b1;
                  rcnt_ff    <= rcnt_ff + 1'b1;
                  fix_idx_ff <= IDX_BITS'(pos_ff - 1'b1);
                  fix_seg_ff <= '{1'b1, before_ff.start, sat({2'b0, nz2})};
               end else if (wprev || wnext) begin
                  rcnt_ff <= rcnt_ff + 1'b1;
               end else if (used_ff < CNT_BITS'(SEGMENTS)) begin
                  used_ff <= used_ff + 1'b1;
                  rcnt_ff <= rcnt_ff + 1'b1;
               end else begin
                  status_ff <= ST_FULL;
               end
               step_ff  <= '0;
               sum_ff   <= '0;
               big_ff   <= '0;
               state_ff <= (kind_ff && len_ff != '0 && wprev && wnext) ? S_FIX : S_SUM;
            end
            S_FIX: state_ff <= S_SUM;
            S_SUM: begin
               if (in_range) begin
                  sum_ff <= sum_ff + {4'b0, head.size};
                  if (head.size > big_ff) big_ff <= head.size;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == CNT_BITS'(SEGMENTS-1)) state_ff <= S_OUT;
            end
            S_OUT: begin
               rvalid_ff <= 1'b1;
               rdata_ff  <= {7'd0, rcnt_ff, acnt_ff, used_ff,
                             sat(sum_ff - {4'b0, big_ff}),
                             sat(sum_ff), got_ff, status_ff};
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rvalid_ff && rsp_tready) rvalid_ff <= 1'b0;
      end
   end

   assign req_tready = state_ff == S_IDLE && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

`ifndef NO_ASSERTIONS
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_BITS'(SEGMENTS)) else $error("segment count overflow");
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> rsp_tvalid) else $error("result lost");
`endif

endmodule

// ===== rtl/core/vpa_cell.sv =====
// ----------------------------------------------------------------------------
// vpa_cell
// one entry of the free segment chain; holds a segment and passes it on
// ----------------------------------------------------------------------------
module vpa_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic [vpa_pkg::IDX_BITS-1:0] pos,
   input  vpa_pkg::ctl_type  ctl,
   input  vpa_pkg::seg_type  first_init,
   input  vpa_pkg::seg_type  prev_seg,
   input  vpa_pkg::seg_type  next_seg,
   output vpa_pkg::seg_type  seg
);
   import vpa_pkg::*;

   seg_type seg_ff, seg_in;

   always_comb begin
      seg_in = seg_ff;
      unique case (ctl.cmd)
         CMD_HOLD:   seg_in = seg_ff;
         CMD_INIT:   seg_in = (pos == '0) ? first_init : '0;
         CMD_ROTATE: seg_in = next_seg;
         CMD_WRITE:  if (pos == ctl.idx) seg_in = ctl.seg;
         CMD_REMOVE: if (pos >= ctl.idx) seg_in = next_seg;
         CMD_INSERT: begin
            if (pos == ctl.idx) seg_in = ctl.seg;
            else if (pos > ctl.idx) seg_in = prev_seg;
         end
         default:    seg_in = seg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= (pos == '0) ? first_init : '0;
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign seg = seg_ff;

endmodule

// ===== rtl/core/vpa_chain.sv =====
// ----------------------------------------------------------------------------
// vpa_chain
// row of segment cells, cell zero at the low address end
// ----------------------------------------------------------------------------
module vpa_chain (
   input  logic             clock,
   input  logic             reset,
   input  vpa_pkg::ctl_type ctl,
   input  vpa_pkg::seg_type first_init,
   output vpa_pkg::seg_type head
);
   import vpa_pkg::*;

   seg_type cells [SEGMENTS];

   for (genvar g = 0; g < SEGMENTS; g++) begin : g_cell
      seg_type prv, nxt;
      assign prv = (g == 0) ? cells[SEGMENTS-1] : cells[(g+SEGMENTS-1)%SEGMENTS];
      // rotation closes the ring; removal fills the top with an empty entry
      assign nxt = (g == SEGMENTS-1) ?
                   ((ctl.cmd == CMD_ROTATE) ? cells[0] : seg_type'('0)) :
                   cells[(g+1)%SEGMENTS];
      vpa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .pos        (IDX_BITS'(g)),
         .ctl        (ctl),
         .first_init (first_init),
         .prev_seg   (prv),
         .next_seg   (nxt),
         .seg        (cells[g])
      );
   end

   assign head = cells[0];

endmodule
